### rtl/core/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// Types, widths and constants shared by the echo ranger's files.
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

   // Readings averaged per measurement run.
   localparam int unsigned SAMPLES = 5;

   localparam int unsigned TRIG_W   = 10;
   localparam int unsigned SETTLE_W = 20;
   localparam int unsigned CNT_W    = 20;
   localparam int unsigned SUM_W    = 23;
   localparam int unsigned DONE_W   = 4;
   localparam int unsigned DIST_W   = 19;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE        = 2'd1;

   localparam logic [TRIG_W-1:0]   TRIGGER_WIDTH_RESET = 10'd30;
   localparam logic [SETTLE_W-1:0] SETTLE_RESET        = 20'd50000;

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_TRIG   = 3'd1;
   localparam logic [2:0] PH_WAIT   = 3'd2;
   localparam logic [2:0] PH_MEAS   = 3'd3;
   localparam logic [2:0] PH_SETTLE = 3'd4;

   localparam logic [CNT_W-1:0]  WIDTH_MAX    = {CNT_W{1'b1}};
   localparam logic [DONE_W-1:0] SAMPLES_DONE = DONE_W'(SAMPLES);

   // Average = floor(sum * 16 / (58 * SAMPLES)). The divide is done as a
   // multiply by a rounded-up reciprocal, exact for every numerator below
   // 2^NUM_W because the shift covers the numerator plus the divisor bits.
   localparam int unsigned SOUND_DIV   = 58;
   localparam int unsigned FRAC_BITS   = 4;
   localparam int unsigned DEN         = SOUND_DIV * SAMPLES;
   localparam int unsigned NUM_W       = SUM_W + FRAC_BITS;
   localparam int unsigned RECIP_SHIFT = NUM_W + $clog2(DEN);
   localparam int unsigned RECIP_W     = NUM_W + 2;
   localparam logic [63:0] RECIP_WIDE  =
      ((64'd1 << RECIP_SHIFT) + 64'(DEN) - 64'd1) / 64'(DEN);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_WIDE[RECIP_W-1:0];
   localparam int unsigned PROD_W      = SUM_W + RECIP_W;
   localparam int unsigned QUOT_LSB    = RECIP_SHIFT - FRAC_BITS;

   typedef struct packed {
      logic echo_level;
      logic start_request;
   } req_type;

   typedef struct packed {
      logic              trigger_out;
      logic              busy_res;
      logic              result_valid;
      logic [DIST_W-1:0] distance_q4_cm;
   } rsp_type;

endpackage : uer_pkg

`default_nettype wire

### rtl/core/uer_req_if.sv
// ----------------------------------------------------------------------------
// uer_req_if
// Valid/ready channel carrying one sampled tick into the ranger.
// ----------------------------------------------------------------------------
`default_nettype none

interface uer_req_if;
   import uer_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface : uer_req_if

`default_nettype wire

### rtl/core/uer_rsp_if.sv
// ----------------------------------------------------------------------------
// uer_rsp_if
// Valid/ready channel carrying one result per tick out of the ranger.
// ----------------------------------------------------------------------------
`default_nettype none

interface uer_rsp_if;
   import uer_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface : uer_rsp_if

`default_nettype wire

### rtl/core/uer_ctrl.sv
// ----------------------------------------------------------------------------
// uer_ctrl
// Measurement sequencer: trigger, echo wait, width count, settle, average.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_ctrl (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_en,
   input  wire logic [uer_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [uer_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                           tick_accept,
   input  wire uer_pkg::req_type               tick,
   output uer_pkg::rsp_type                    result
);
   import uer_pkg::*;

   logic [TRIG_W-1:0]   trigger_width_ff;
   logic [SETTLE_W-1:0] settle_ff;

   logic [2:0]          phase_ff, phase_in;
   logic [CNT_W-1:0]    tick_cnt_ff, tick_cnt_in;
   logic [CNT_W-1:0]    echo_cnt_ff, echo_cnt_in;
   logic [SUM_W-1:0]    width_sum_ff, width_sum_in;
   logic [DONE_W-1:0]   done_ff, done_in;
   logic [DIST_W-1:0]   distance_ff, distance_in;
   logic                valid_in;

   logic [CNT_W-1:0]    tick_cnt_inc;
   logic [PROD_W-1:0]   avg_prod;
   logic [DIST_W-1:0]   avg_q4;

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_width_ff <= TRIGGER_WIDTH_RESET;
         settle_ff        <= SETTLE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_TRIGGER_WIDTH: trigger_width_ff <= csr_wdata[TRIG_W-1:0];
            CSR_SETTLE:        settle_ff        <= csr_wdata[SETTLE_W-1:0];
            default: ;
         endcase
      end
   end

   // The running sum never changes on the tick that closes the settle time,
   // so the average is taken straight from the registered sum.
   assign avg_prod     = PROD_W'(width_sum_ff) * PROD_W'(RECIP);
   assign avg_q4       = avg_prod[QUOT_LSB +: DIST_W];
   assign tick_cnt_inc = tick_cnt_ff + 1'b1;

   always_comb begin
      phase_in     = phase_ff;
      tick_cnt_in  = tick_cnt_ff;
      echo_cnt_in  = echo_cnt_ff;
      width_sum_in = width_sum_ff;
      done_in      = done_ff;
      distance_in  = distance_ff;
      valid_in     = 1'b0;
      case (phase_ff)
         PH_TRIG: begin
            tick_cnt_in = tick_cnt_inc;
            if (tick_cnt_inc >= CNT_W'(trigger_width_ff)) begin
               phase_in    = PH_WAIT;
               tick_cnt_in = '0;
            end
         end
         PH_WAIT: begin
            if (tick.echo_level) begin
               phase_in    = PH_MEAS;
               echo_cnt_in = CNT_W'(1);
            end
         end
         PH_MEAS: begin
            if (tick.echo_level) begin
               if (echo_cnt_ff != WIDTH_MAX) begin
                  echo_cnt_in = echo_cnt_ff + 1'b1;
               end
            end else begin
               width_sum_in = width_sum_ff + SUM_W'(echo_cnt_ff);
               done_in      = done_ff + 1'b1;
               phase_in     = PH_SETTLE;
               tick_cnt_in  = '0;
            end
         end
         PH_SETTLE: begin
            tick_cnt_in = tick_cnt_inc;
            if (tick_cnt_inc >= settle_ff) begin
               tick_cnt_in = '0;
               if (done_ff >= SAMPLES_DONE) begin
                  distance_in = avg_q4;
                  valid_in    = 1'b1;
                  phase_in    = PH_IDLE;
               end else begin
                  phase_in = PH_TRIG;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if (tick.start_request) begin
               phase_in     = PH_TRIG;
               tick_cnt_in  = '0;
               echo_cnt_in  = '0;
               width_sum_in = '0;
               done_in      = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_cnt_ff  <= '0;
         echo_cnt_ff  <= '0;
         width_sum_ff <= '0;
         done_ff      <= '0;
         distance_ff  <= '0;
      end else if (tick_accept) begin
         phase_ff     <= phase_in;
         tick_cnt_ff  <= tick_cnt_in;
         echo_cnt_ff  <= echo_cnt_in;
         width_sum_ff <= width_sum_in;
         done_ff      <= done_in;
         distance_ff  <= distance_in;
      end
   end

   always_comb begin
      result.trigger_out    = (phase_in == PH_TRIG);
      result.busy_res       = (phase_in != PH_IDLE);
      result.result_valid   = valid_in;
      result.distance_q4_cm = distance_in;
   end

   a_valid_ends_run: assert property (@(posedge clock) disable iff (reset)
      result.result_valid |-> !result.busy_res)
      else $error("average produced while the run is still busy");

   a_trigger_busy: assert property (@(posedge clock) disable iff (reset)
      result.trigger_out |-> result.busy_res)
      else $error("trigger driven while idle");

   a_reading_counted: assert property (@(posedge clock) disable iff (reset)
      tick_accept && phase_ff == PH_MEAS && !tick.echo_level
      |=> done_ff == $past(done_ff) + 1'b1)
      else $error("echo end did not count a reading");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !tick_accept |=> $stable(phase_ff) && $stable(width_sum_ff))
      else $error("sequencer state moved without a transfer");

endmodule : uer_ctrl

`default_nettype wire

### rtl/core/uer_outbuf.sv
// ----------------------------------------------------------------------------
// uer_outbuf
// Two-entry result buffer: an output register plus a skid register.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_outbuf (
   input  wire logic             clock,
   input  wire logic             reset,
   output logic                  in_ready,
   input  wire logic             in_accept,
   input  wire uer_pkg::rsp_type in_data,
   uer_rsp_if.source             rsp_if
);
   import uer_pkg::*;

   logic    out_valid_ff, skid_valid_ff;
   rsp_type out_data_ff, skid_data_ff;
   logic    pop;

   assign pop            = out_valid_ff && rsp_if.ready;
   assign in_ready       = !skid_valid_ff;
   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (in_accept) begin
         if (out_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (in_accept) begin
         if (out_valid_ff && !pop) begin
            skid_data_ff <= in_data;
         end else begin
            out_data_ff <= in_data;
         end
      end
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with an empty output register");

   a_full_drains_skid: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && pop |=> out_valid_ff && !skid_valid_ff)
      else $error("skid entry not moved forward on a transfer");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      in_accept |-> !skid_valid_ff)
      else $error("result taken while both entries are full");

endmodule : uer_outbuf

`default_nettype wire

### rtl/core/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Echo-pulse ranger: averages SAMPLES echo widths into a distance in cm (Q4).
//
//   Channel   Dir  Handshake      Contents
//   req_if    in   valid/ready    one microsecond tick: echo level, start
//   rsp_if    out  valid/ready    trigger, busy, result valid, distance
//   csr_*     in   write enable   trigger width (index 0), settle time (1)
//
// One tick is taken per clock while req_if.ready is high; its result, formed
// combinationally by the sequencer and the sum-to-distance multiply, goes to
// the output register or, while it is full, the skid register. The two-entry
// buffer keeps req_if.ready high while one result waits; it drops only when
// two results are held. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_ranger (
   input  wire logic                           clock,
   input  wire logic                           reset,
   uer_req_if.sink                             req_if,
   uer_rsp_if.source                           rsp_if,
   input  wire logic                           csr_write_en,
   input  wire logic [uer_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [uer_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import uer_pkg::*;

   logic    buf_ready;
   logic    tick_accept;
   rsp_type result;

   assign req_if.ready = buf_ready;
   assign tick_accept  = req_if.valid && buf_ready;

   uer_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .tick_accept  (tick_accept),
      .tick         (req_if.payload),
      .result       (result)
   );

   uer_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_ready  (buf_ready),
      .in_accept (tick_accept),
      .in_data   (result),
      .rsp_if    (rsp_if)
   );

endmodule : ultrasonic_echo_ranger

`default_nettype wire
